### rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes and helpers for the bounded deque with purge.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 16;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // Port widths fixed by the interface
  localparam int OPCODE_W = 3;
  localparam int VAL_W    = 16;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PURGE      = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_MIN_MAX    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_READ_FWD   = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_READ_REV   = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [VALUE_WIDTH-1:0] val_t;

  // Physical slot of the entry at offset off from the front (circular store)
  function automatic idx_t slot(input idx_t head, input idx_t off);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, off};
    if (sum >= (IDX_W + 1)'(CAPACITY)) begin
      sum = sum - (IDX_W + 1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Slot just ahead of the front, wrapping at the start of the store
  function automatic idx_t slot_dec(input idx_t head);
    idx_t res;
    if (head == '0) begin
      res = IDX_W'(CAPACITY - 1);
    end else begin
      res = head - 1'b1;
    end
    return res;
  endfunction

endpackage

### rtl/bounded_deque_with_purge.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_purge
// Circular-buffer deque with push at either end, purge by value, min/max
// and full read-out, walked one entry a cycle through the single store read port.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------
//  command  | start, busy          | opcode, operand_value
//  result   | valid (one-cycle)    | result_value, result_min, result_count,
//           |                      | status, last
//
//  Pushes, and purge, min max or reads on an empty store, answer with a
//  registered result beat and busy left low. Otherwise purge, min max and
//  reads walk the stored entries through the single read port of the
//  entry store, one entry a cycle, with busy held high until the walk ends.
//  Reads give one result beat per entry during the walk. Reset clears the
//  length and front pointer; the entry store itself is not cleared. The
//  receiver cannot stall: each result beat is shown for exactly one cycle.
//  Opcodes six and seven are ignored.

module bounded_deque_with_purge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bdq_pkg::OPCODE_W-1:0]  opcode,
  input  logic [bdq_pkg::VAL_W-1:0]     operand_value,
  output logic                          valid,
  output logic [bdq_pkg::VAL_W-1:0]     result_value,
  output logic [bdq_pkg::VAL_W-1:0]     result_min,
  output logic [bdq_pkg::COUNT_W-1:0]   result_count,
  output logic [bdq_pkg::STATUS_W-1:0]  status,
  output logic                          last
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic                              state;
  bdq_pkg::idx_t                     head;
  bdq_pkg::cnt_t                     len;
  logic [bdq_pkg::OPCODE_W-1:0]      op_r;
  bdq_pkg::val_t                     val_r;
  bdq_pkg::cnt_t                     rd_i;
  bdq_pkg::cnt_t                     wr_i;
  logic                              dv;
  bdq_pkg::idx_t                     dv_i;
  bdq_pkg::val_t                     mn;
  bdq_pkg::val_t                     mx;

  // Entry store
  bdq_pkg::val_t                     mem [bdq_pkg::CAPACITY];
  bdq_pkg::val_t                     mem_q;
  logic                              mem_we;
  bdq_pkg::idx_t                     mem_wa;
  bdq_pkg::val_t                     mem_wd;
  bdq_pkg::idx_t                     mem_ra;

  logic                              accept;
  logic                              is_push;
  logic                              full;
  bdq_pkg::val_t                     in_val;
  bdq_pkg::cnt_t                     rev_off;
  logic                              keep;
  bdq_pkg::cnt_t                     wr_next;
  logic                              walk_end;
  bdq_pkg::val_t                     mn_next;
  bdq_pkg::val_t                     mx_next;

  assign busy    = (state == S_WALK);
  assign accept  = start && !busy;
  assign in_val  = operand_value[bdq_pkg::VALUE_WIDTH-1:0];
  assign full    = (len == bdq_pkg::cnt_t'(bdq_pkg::CAPACITY));
  assign is_push = (opcode == bdq_pkg::OP_PUSH_FRONT) || (opcode == bdq_pkg::OP_PUSH_BACK);

  // Walk datapath: compare the returned entry against the purge value and bounds
  assign keep     = (mem_q != val_r);
  assign wr_next  = wr_i + bdq_pkg::cnt_t'(keep);
  assign walk_end = dv && (bdq_pkg::cnt_t'(dv_i) == len - 1'b1);
  assign mn_next  = (mem_q < mn) ? mem_q : mn;
  assign mx_next  = (mem_q > mx) ? mem_q : mx;
  assign rev_off  = len - 1'b1 - rd_i;

  // Read address: forward or reverse order from the front
  always_comb begin
    if (op_r == bdq_pkg::OP_READ_REV) begin
      mem_ra = bdq_pkg::slot(head, rev_off[bdq_pkg::IDX_W-1:0]);
    end else begin
      mem_ra = bdq_pkg::slot(head, rd_i[bdq_pkg::IDX_W-1:0]);
    end
  end

  // Write port: pushes from idle, compaction writes during a purge walk
  always_comb begin
    mem_we = 1'b0;
    mem_wa = bdq_pkg::slot(head, wr_i[bdq_pkg::IDX_W-1:0]);
    mem_wd = mem_q;
    if (state == S_WALK) begin
      mem_we = dv && (op_r == bdq_pkg::OP_PURGE) && keep;
    end else if (accept && is_push && !full) begin
      mem_we = 1'b1;
      mem_wd = in_val;
      if (opcode == bdq_pkg::OP_PUSH_FRONT) begin
        mem_wa = bdq_pkg::slot_dec(head);
      end else begin
        mem_wa = bdq_pkg::slot(head, len[bdq_pkg::IDX_W-1:0]);
      end
    end
  end

  // Store: one write, one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  // Sequencer, pointers and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      len   <= '0;
      valid <= 1'b0;
      dv    <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_r         <= opcode;
            val_r        <= in_val;
            rd_i         <= '0;
            wr_i         <= '0;
            dv           <= 1'b0;
            mn           <= '1;
            mx           <= '0;
            result_value <= '0;
            result_min   <= '0;
            last         <= 1'b1;
            case (opcode) inside
              bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
                valid <= 1'b1;
                if (full) begin
                  status       <= bdq_pkg::ST_FULL;
                  result_count <= bdq_pkg::COUNT_W'(len);
                end else begin
                  status       <= bdq_pkg::ST_OK;
                  result_count <= bdq_pkg::COUNT_W'(len + 1'b1);
                  len          <= len + 1'b1;
                  if (opcode == bdq_pkg::OP_PUSH_FRONT) begin
                    head <= bdq_pkg::slot_dec(head);
                  end
                end
              end
              [bdq_pkg::OP_PURGE : bdq_pkg::OP_READ_REV]: begin
                if (len == '0) begin
                  valid        <= 1'b1;
                  status       <= bdq_pkg::ST_EMPTY;
                  result_count <= '0;
                end else begin
                  state <= S_WALK;
                end
              end
              default: begin
                // unused opcode: drop it
              end
            endcase
          end
        end
        S_WALK: begin
          // Issue the next read while entries remain
          if (rd_i < len) begin
            rd_i <= rd_i + 1'b1;
            dv   <= 1'b1;
            dv_i <= rd_i[bdq_pkg::IDX_W-1:0];
          end else begin
            dv <= 1'b0;
          end
          // Consume the entry returned by the previous read
          if (dv) begin
            case (op_r)
              bdq_pkg::OP_PURGE: begin
                wr_i <= wr_next;
                if (walk_end) begin
                  valid        <= 1'b1;
                  last         <= 1'b1;
                  result_count <= bdq_pkg::COUNT_W'(len - wr_next);
                  status       <= (wr_next == len) ? bdq_pkg::ST_NOT_FOUND : bdq_pkg::ST_OK;
                  len          <= wr_next;
                end
              end
              bdq_pkg::OP_MIN_MAX: begin
                mn <= mn_next;
                mx <= mx_next;
                if (walk_end) begin
                  valid        <= 1'b1;
                  last         <= 1'b1;
                  result_value <= bdq_pkg::VAL_W'(mx_next);
                  result_min   <= bdq_pkg::VAL_W'(mn_next);
                  result_count <= bdq_pkg::COUNT_W'(len);
                  status       <= bdq_pkg::ST_OK;
                end
              end
              default: begin
                // read forward or reverse: one beat per entry
                valid        <= 1'b1;
                last         <= walk_end;
                result_value <= bdq_pkg::VAL_W'(mem_q);
                result_min   <= '0;
                result_count <= bdq_pkg::COUNT_W'(len);
                status       <= bdq_pkg::ST_OK;
              end
            endcase
            if (walk_end) begin
              state <= S_IDLE;
              dv    <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
